FILE: src/sha1hc_pkg.sv
// ----------------------------------------------------------------------------
// sha1hc_pkg
// Shared types and constants of the SHA-1 hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1hc_pkg;

   // chaining values after reset and after every digest
   localparam logic [31:0] H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // round constants, one per group of twenty rounds
   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // word queue between front and back
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // one big-endian message word on its way to the compression unit
   typedef struct packed {
      logic [31:0] data;
      logic        blk_end;   // sixteenth word of a block
      logic        final_blk; // closing block of a message
   } qword_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

FILE: src/sha1hc_if.sv
// ----------------------------------------------------------------------------
// sha1hc_req_if / sha1hc_rsp_if
// Valid/ready channels of the SHA-1 hash core.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1hc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink (input valid, action, data_byte, output ready);
   modport monitor (input valid, ready, action, data_byte);
endinterface

interface sha1hc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        last_word;

   modport source (output valid, digest_word, last_word, input ready);
   modport sink (input valid, digest_word, last_word, output ready);
   modport monitor (input valid, ready, digest_word, last_word);
endinterface

`default_nettype wire

FILE: src/sha1_hash_core_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_core_unit
// SHA-1 digest engine: byte requests in, five digest words out per message.
// ----------------------------------------------------------------------------
// A request either absorbs one message byte (action 0) or finishes the message
// (action 1). The front takes one byte request per cycle while it is not
// padding and the queue is not full, and packs words into a 16-word queue;
// the back loads 16 words and then runs the 80 rounds one per cycle, followed
// by the chaining add. The front stalls while the queue is full and while it
// pads and appends the length. A finish request adds padding at one byte per
// cycle while the queue is not full, and the five digest words come out on
// the response channel, word 0 first, last_word on word 4.
`default_nettype none

module sha1_hash_core_unit (
   input  wire logic      clock,
   input  wire logic      reset,
   sha1hc_req_if.sink     req_if,
   sha1hc_rsp_if.source   rsp_if
);
   import sha1hc_pkg::*;

   qword_type push_word, pop_word;
   qstat_type qstat;
   logic      push, pop;

   sha1hc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .qstat     (qstat),
      .push      (push),
      .push_word (push_word)
   );

   sha1hc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .qstat     (qstat)
   );

   sha1hc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_word (pop_word),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

FILE: src/sha1hc_front.sv
// ----------------------------------------------------------------------------
// sha1hc_front
// Takes requests, appends padding and length, packs bytes into words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   sha1hc_req_if.sink             req_if,
   input  sha1hc_pkg::qstat_type  qstat,
   output logic                   push,
   output sha1hc_pkg::qword_type  push_word
);
   import sha1hc_pkg::*;

   typedef enum logic [2:0] {
      F_DATA = 3'b001,
      F_PAD  = 3'b010,
      F_LEN  = 3'b100
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;
   logic [23:0] acc_ff, acc_in;

   logic       byte_go;
   logic [7:0] byte_val;
   logic       final_go;

   // byte source selection
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      byte_go       = 1'b0;
      byte_val      = 8'h00;
      final_go      = 1'b0;
      req_if.ready  = 1'b0;
      case (state_ff)
         F_DATA: begin
            req_if.ready = !qstat.full;
            if (req_if.valid && !qstat.full) begin
               byte_go = 1'b1;
               if (req_if.action == ACT_FINISH) begin
                  byte_val = PAD_BYTE;
                  len_in   = {count_ff[60:0], 3'b000};
                  state_in = F_PAD;
               end else begin
                  byte_val = req_if.data_byte;
               end
            end
         end
         F_PAD: begin
            if (count_ff[5:0] == 6'd56) begin
               state_in = F_LEN;
            end else if (!qstat.full) begin
               byte_go = 1'b1;
            end
         end
         F_LEN: begin
            if (!qstat.full) begin
               byte_go  = 1'b1;
               byte_val = len_ff[63:56];
               len_in   = {len_ff[55:0], 8'h00};
               if (count_ff[5:0] == 6'd63) begin
                  final_go = 1'b1;
                  state_in = F_DATA;
               end
            end
         end
         default: state_in = F_DATA;
      endcase
   end

   // count and word packing
   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      push     = 1'b0;
      push_word.data      = {acc_ff, byte_val};
      push_word.blk_end   = (count_ff[5:0] == 6'd63);
      push_word.final_blk = final_go;
      if (byte_go) begin
         count_in = final_go ? 64'd0 : count_ff + 64'd1;
         acc_in   = {acc_ff[15:0], byte_val};
         push     = (count_ff[1:0] == 2'b11);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_DATA;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      len_ff <= len_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

FILE: src/sha1hc_queue.sv
// ----------------------------------------------------------------------------
// sha1hc_queue
// Small word FIFO that decouples the front from the compression unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  sha1hc_pkg::qword_type  push_word,
   input  wire logic              pop,
   output sha1hc_pkg::qword_type  pop_word,
   output sha1hc_pkg::qstat_type  qstat
);
   import sha1hc_pkg::*;

   qword_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   logic do_push, do_pop;

   assign qstat.full  = (cnt_ff == QUEUE_DEPTH[QPTR_W:0]);
   assign qstat.empty = (cnt_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_word    = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (do_push) slot_ff[wr_ff] <= push_word;
   end

endmodule

`default_nettype wire

FILE: src/sha1hc_back.sv
// ----------------------------------------------------------------------------
// sha1hc_back
// Loads block words, runs 80 SHA-1 rounds, keeps chaining words, emits digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  sha1hc_pkg::qword_type  pop_word,
   input  sha1hc_pkg::qstat_type  qstat,
   output logic                   pop,
   sha1hc_rsp_if.source           rsp_if
);
   import sha1hc_pkg::*;

   typedef enum logic [3:0] {
      B_LOAD  = 4'b0001,
      B_ROUND = 4'b0010,
      B_ADD   = 4'b0100,
      B_EMIT  = 4'b1000
   } bstate_type;

   bstate_type  state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] chain_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  rnd_ff;
   logic        final_ff;
   logic [2:0]  idx_ff;

   logic [31:0] fn, kc, tmp, w_mix, w_new;
   logic        rsp_go;

   assign pop    = (state_ff == B_LOAD) && !qstat.empty;
   assign rsp_go = rsp_if.valid && rsp_if.ready;

   // round function and message schedule
   always_comb begin
      if (rnd_ff < 7'd20) begin
         fn = (b_ff & c_ff) | (~b_ff & d_ff);
         kc = K_R0;
      end else if (rnd_ff < 7'd40) begin
         fn = b_ff ^ c_ff ^ d_ff;
         kc = K_R1;
      end else if (rnd_ff < 7'd60) begin
         fn = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         kc = K_R2;
      end else begin
         fn = b_ff ^ c_ff ^ d_ff;
         kc = K_R3;
      end
      tmp   = {a_ff[26:0], a_ff[31:27]} + fn + e_ff + kc + w_ff[0];
      w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_mix[30:0], w_mix[31]};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_LOAD:  if (pop && pop_word.blk_end) state_in = B_ROUND;
         B_ROUND: if (rnd_ff == 7'd79) state_in = B_ADD;
         B_ADD:   state_in = final_ff ? B_EMIT : B_LOAD;
         B_EMIT:  if (rsp_go && idx_ff == 3'd4) state_in = B_LOAD;
         default: state_in = B_LOAD;
      endcase
   end

   assign rsp_if.valid       = (state_ff == B_EMIT);
   assign rsp_if.digest_word = chain_ff[idx_ff];
   assign rsp_if.last_word   = (idx_ff == 3'd4);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_LOAD;
         for (int i = 0; i < 5; i++) chain_ff[i] <= H_INIT[i];
         rnd_ff   <= '0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            // shift words in, latch working variables on the last one
            B_LOAD: begin
               if (pop) begin
                  for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
                  w_ff[15] <= pop_word.data;
                  if (pop_word.blk_end) begin
                     final_ff <= pop_word.final_blk;
                     rnd_ff   <= '0;
                     a_ff <= chain_ff[0];
                     b_ff <= chain_ff[1];
                     c_ff <= chain_ff[2];
                     d_ff <= chain_ff[3];
                     e_ff <= chain_ff[4];
                  end
               end
            end
            // one round per cycle
            B_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= w_new;
               e_ff   <= d_ff;
               d_ff   <= c_ff;
               c_ff   <= {b_ff[1:0], b_ff[31:2]};
               b_ff   <= a_ff;
               a_ff   <= tmp;
               rnd_ff <= rnd_ff + 7'd1;
            end
            B_ADD: begin
               chain_ff[0] <= chain_ff[0] + a_ff;
               chain_ff[1] <= chain_ff[1] + b_ff;
               chain_ff[2] <= chain_ff[2] + c_ff;
               chain_ff[3] <= chain_ff[3] + d_ff;
               chain_ff[4] <= chain_ff[4] + e_ff;
               idx_ff      <= '0;
            end
            // hand out digest, then restart chaining
            B_EMIT: begin
               if (rsp_go) begin
                  if (idx_ff == 3'd4) begin
                     for (int i = 0; i < 5; i++) chain_ff[i] <= H_INIT[i];
                     idx_ff <= '0;
                  end else begin
                     idx_ff <= idx_ff + 3'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: src/sha1hc_checker.sv
// ----------------------------------------------------------------------------
// sha1hc_checker
// Port-level checks of the SHA-1 hash core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hc_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   sha1hc_req_if.sink      req_if,
   sha1hc_rsp_if.source    rsp_if
);

   // stalled request keeps its action
   a_req_stable: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && !req_if.ready |=> $stable(req_if.action))
      else $error("request changed while stalled");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> $stable(rsp_if.digest_word))
      else $error("digest word changed while stalled");

   // digest ends cleanly after its last word
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.last_word |=> !rsp_if.valid)
      else $error("response follows last digest word");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

endmodule

bind sha1_hash_core_unit sha1hc_checker u_sha1hc_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

`default_nettype wire

FILE: tb/sha1hc_tb_pkg.sv
// ----------------------------------------------------------------------------
// sha1hc_tb_pkg
// Digest predictor and digest-word scoreboard for the SHA-1 hash core bench.
// ----------------------------------------------------------------------------
// The predictor keeps its own chaining words, byte count and block buffer,
// pads on a finish request and queues the five digest words it expects.
package sha1hc_tb_pkg;
   import sha1hc_pkg::*;

   typedef struct {
      logic [31:0] digest_word;
      logic        last_word;
   } digest_exp_type;

   class sha1_digest_board;
      logic [31:0]    chain[5];
      logic [63:0]    msg_bytes;
      logic [7:0]     blk[64];
      digest_exp_type pending_words[$];
      int             fail_cnt;

      function new();
         restart();
         fail_cnt = 0;
      endfunction

      function void restart();
         for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
         msg_bytes = '0;
      endfunction

      function logic [31:0] rol(logic [31:0] x, int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      // 80-round compression of the buffered block
      function void compress();
         logic [31:0] w[80];
         logic [31:0] a, b, c, d, e, f, k, t;
         for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
         for (int r = 16; r < 80; r++)
            w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
               f = (b & c) | (~b & d); k = K_R0;
            end else if (r < 40) begin
               f = b ^ c ^ d; k = K_R1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d); k = K_R2;
            end else begin
               f = b ^ c ^ d; k = K_R3;
            end
            t = rol(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      endfunction

      function void absorb(logic [7:0] v);
         int pos;
         pos = int'(msg_bytes[5:0]);
         blk[pos] = v;
         msg_bytes++;
         if (pos == 63) compress();
      endfunction

      // note one accepted request
      function void note_request(logic action, logic [7:0] data_byte);
         logic [63:0] bit_len;
         digest_exp_type x;
         if (action == ACT_ABSORB) begin
            absorb(data_byte);
            return;
         end
         bit_len = msg_bytes << 3;
         absorb(PAD_BYTE);
         while (msg_bytes[5:0] != 6'd56) absorb(8'h00);
         for (int i = 7; i >= 0; i--) absorb(bit_len[i*8 +: 8]);
         for (int i = 0; i < 5; i++) begin
            x.digest_word = chain[i];
            x.last_word   = (i == 4);
            pending_words.insert(pending_words.size(), x);
         end
         restart();
      endfunction

      function void report(string what);
         $display("mismatch: %s", what);
         fail_cnt++;
      endfunction

      // compare one accepted digest word with the oldest expectation
      function void check_word(logic [31:0] digest_word, logic last_word);
         digest_exp_type x;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word %h", digest_word));
            return;
         end
         x = pending_words.pop_front();
         if (digest_word !== x.digest_word)
            report($sformatf("digest_word %h, want %h", digest_word, x.digest_word));
         if (last_word !== x.last_word)
            report($sformatf("last_word %b, want %b", last_word, x.last_word));
      endfunction
   endclass
endpackage

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the SHA-1 hash core.
// ----------------------------------------------------------------------------
// Directed messages (empty, padding edges, block boundaries, finish with a
// set data byte) then random messages of mostly short length, under three
// idle mixes, a long response hold-off and a drain pause.
module tb_top;
   import sha1hc_pkg::*;
   import sha1hc_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_rsp;
   int   quiet_cycles;

   sha1hc_req_if req_if();
   sha1hc_rsp_if rsp_if();

   sha1_digest_board board;

   sha1_hash_core_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
      req_if.valid = 0;
      req_if.action = 0;
      req_if.data_byte = 0;
      rsp_if.ready = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_rsp = 0;
   end

   // monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            board.note_request(req_if.action, req_if.data_byte);
         if (rsp_if.valid && rsp_if.ready)
            board.check_word(rsp_if.digest_word, rsp_if.last_word);
      end
   end

   // response ready with random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // send one request, with optional random idle cycles before it
   task automatic send_request(logic action, logic [7:0] data_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= action;
      req_if.data_byte <= data_byte;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) send_request(ACT_ABSORB, 8'($urandom_range(255)));
      send_request(ACT_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_words.size() != 0) @(posedge clock);
   endtask

   int sent;
   int len;

   initial begin
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty message, finish with data byte set, padding edges
      send_request(ACT_FINISH, 8'h00);
      send_request(ACT_FINISH, 8'hFF);
      send_request(ACT_ABSORB, 8'h00);
      send_request(ACT_ABSORB, 8'hFF);
      send_request(ACT_ABSORB, 8'hA5);
      send_request(ACT_ABSORB, 8'h5A);
      send_request(ACT_FINISH, 8'h00);
      send_message(55);
      send_message(56);
      send_message(63);
      send_message(64);
      wait_drain();

      // long response hold-off while requests keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (800) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            for (int m = 0; m < 4; m++) send_message($urandom_range(12));
         end
      join
      wait_drain();

      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
         recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
         while (sent < 50 * (phase + 1)) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(65, 80) : $urandom_range(20);
            send_message(len);
            sent += len + 1;
         end
      end

      wait_drain();
      repeat (200) @(posedge clock);
      if (board.fail_cnt == 0 && board.pending_words.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

FILE: files.f
src/sha1hc_pkg.sv
src/sha1hc_if.sv
src/sha1hc_front.sv
src/sha1hc_queue.sv
src/sha1hc_back.sv
src/sha1_hash_core_unit.sv
src/sha1hc_checker.sv
tb/sha1hc_tb_pkg.sv
tb/tb_top.sv
